/* design/ttvh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ttvh_pkg;

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 11;
  localparam int VAL_W       = 12;
  localparam int OUT_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] char_byte;
    logic [IDX_W-1:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] lines_seen;
    logic [OUT_W-1:0] dropped_values;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SAW_O,
    PH_SAW_OR,
    PH_DIGITS,
    PH_OVF,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_BIN,
    CMD_DROP,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             line_inc;
    logic [VAL_W-1:0] idx;
  } queue_entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

/* design/text_tag_value_histogram.sv */
// Takes one item per cycle while in_ready is high; a four-entry queue parts byte
// scanning from bin updates. A read result passes the queue, update stage and output
// register. Bin updates are read-modify-writes on one memory, one per cycle unless the
// output stalls, with write forwarding. After reset the bin memory is cleared, one bin
// per cycle, while in_ready stays low. Counters and scan state reset to zero and idle.
`timescale 1ns / 1ps
`default_nettype none

module text_tag_value_histogram #(
  parameter int NUM_BINS    = 1260,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire ttvh_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output ttvh_pkg::out_item_t     out_data
);

  logic                   q_push;
  logic                   q_ready;
  logic                   q_pop;
  logic                   head_valid;
  ttvh_pkg::queue_entry_t q_entry;
  ttvh_pkg::queue_entry_t head;
  ttvh_pkg::back_status_t status;

  ttvh_front #(
    .NUM_BINS(NUM_BINS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .status   (status)
  );

  ttvh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .entry      (q_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ttvh_back #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

/* design/ttvh_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttvh_front #(
  parameter int NUM_BINS = 1260
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire ttvh_pkg::in_item_t     in_data,
  input  wire                         q_ready,
  output logic                        q_push,
  output ttvh_pkg::queue_entry_t      q_entry,
  input  wire ttvh_pkg::back_status_t status
);

  ttvh_pkg::phase_t                 phase_r, phase_nxt;
  logic [ttvh_pkg::VAL_W-1:0]       acc_r, acc_nxt;
  logic                             accept;
  logic                             is_digit;
  logic [ttvh_pkg::VAL_W+3:0]       nv;
  ttvh_pkg::cmd_kind_t              rec_kind;
  logic [ttvh_pkg::VAL_W-1:0]       rec_idx;
  logic [ttvh_pkg::BYTE_W-1:0]      b;

  assign in_ready = q_ready && !status.clearing;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;
  assign b        = in_data.char_byte;
  assign is_digit = (b >= ttvh_pkg::CH_0) && (b <= ttvh_pkg::CH_9);
  assign nv       = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {12'b0, b[3:0]};

  // A finished value goes to bin value-1, or to the drop count when it is
  // zero or empty, too large for the bins, or overflowed the accumulator.
  always_comb begin
    rec_idx = acc_r - ttvh_pkg::VAL_W'(1);
    if (phase_r == ttvh_pkg::PH_OVF || acc_r == '0 ||
        acc_r > ttvh_pkg::VAL_W'(NUM_BINS)) begin
      rec_kind = ttvh_pkg::CMD_DROP;
    end else begin
      rec_kind = ttvh_pkg::CMD_BIN;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    acc_nxt          = acc_r;
    q_entry.kind     = ttvh_pkg::CMD_NONE;
    q_entry.line_inc = 1'b0;
    q_entry.idx      = {1'b0, in_data.bin_index};
    if (accept) begin
      if (in_data.op == ttvh_pkg::OP_READ) begin
        q_entry.kind = ttvh_pkg::CMD_READ;
      end else if (b == ttvh_pkg::CH_NL) begin
        if (phase_r == ttvh_pkg::PH_DIGITS || phase_r == ttvh_pkg::PH_OVF) begin
          q_entry.kind = rec_kind;
          q_entry.idx  = rec_idx;
        end
        q_entry.line_inc = 1'b1;
        phase_nxt        = ttvh_pkg::PH_SEARCH;
        acc_nxt          = '0;
      end else begin
        case (phase_r)
          ttvh_pkg::PH_SEARCH, ttvh_pkg::PH_SAW_O, ttvh_pkg::PH_SAW_OR: begin
            if (b == ttvh_pkg::CH_NUL) begin
              phase_nxt = ttvh_pkg::PH_DONE;
            end else if (b == ttvh_pkg::CH_O) begin
              phase_nxt = ttvh_pkg::PH_SAW_O;
            end else if (b == ttvh_pkg::CH_R && phase_r == ttvh_pkg::PH_SAW_O) begin
              phase_nxt = ttvh_pkg::PH_SAW_OR;
            end else if (b == ttvh_pkg::CH_COLON && phase_r == ttvh_pkg::PH_SAW_OR) begin
              phase_nxt = ttvh_pkg::PH_DIGITS;
              acc_nxt   = '0;
            end else begin
              phase_nxt = ttvh_pkg::PH_SEARCH;
            end
          end
          ttvh_pkg::PH_DIGITS, ttvh_pkg::PH_OVF: begin
            if (is_digit) begin
              if (phase_r == ttvh_pkg::PH_DIGITS) begin
                if (nv[ttvh_pkg::VAL_W+3:ttvh_pkg::VAL_W] != '0) begin
                  phase_nxt = ttvh_pkg::PH_OVF;
                end else begin
                  acc_nxt = nv[ttvh_pkg::VAL_W-1:0];
                end
              end
            end else begin
              q_entry.kind = rec_kind;
              q_entry.idx  = rec_idx;
              phase_nxt    = ttvh_pkg::PH_DONE;
            end
          end
          default: begin
            phase_nxt = ttvh_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ttvh_pkg::PH_SEARCH;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/ttvh_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttvh_queue (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  wire ttvh_pkg::queue_entry_t entry,
  output logic                        ready,
  input  wire                         pop,
  output logic                        head_valid,
  output ttvh_pkg::queue_entry_t      head
);

  ttvh_pkg::queue_entry_t      entries_r [ttvh_pkg::QUEUE_DEPTH];
  logic [ttvh_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ttvh_pkg::QPTR_W:0]   count_r, count_nxt;

  assign ready      = count_r != (ttvh_pkg::QPTR_W+1)'(ttvh_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (ttvh_pkg::QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (ttvh_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ttvh_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ttvh_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (ready || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

/* design/ttvh_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttvh_back #(
  parameter int NUM_BINS    = 1260,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         head_valid,
  input  wire ttvh_pkg::queue_entry_t head,
  output logic                        pop,
  output ttvh_pkg::back_status_t      status,
  output logic                        out_valid,
  input  wire                         out_ready,
  output ttvh_pkg::out_item_t         out_data
);

  localparam int ADDR_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic [COUNT_WIDTH-1:0]  mem [NUM_BINS];

  logic                    clr_active_r;
  logic [ADDR_W-1:0]       clr_idx_r;
  logic                    b_valid_r;
  ttvh_pkg::queue_entry_t  b_entry_r;
  logic [COUNT_WIDTH-1:0]  rd_data_r;
  logic                    fwd_valid_r;
  logic [ADDR_W-1:0]       fwd_addr_r;
  logic [COUNT_WIDTH-1:0]  fwd_data_r;
  logic [COUNT_WIDTH-1:0]  line_cnt_r;
  logic [COUNT_WIDTH-1:0]  drop_cnt_r;
  logic                    out_valid_r;
  ttvh_pkg::out_item_t     out_data_r;

  logic                    b_is_read;
  logic                    adv;
  logic [ADDR_W-1:0]       b_addr;
  logic [COUNT_WIDTH-1:0]  cur;
  logic [COUNT_WIDTH-1:0]  cur_inc;
  logic                    b_write;
  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [COUNT_WIDTH-1:0]  wdata;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [ttvh_pkg::OUT_W-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w[63:32] != '0) ? '1 : w[31:0];
  endfunction

  assign status.clearing = clr_active_r;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  assign b_is_read = b_valid_r && (b_entry_r.kind == ttvh_pkg::CMD_READ);
  // The update stage holds while the memory is cleared and when a read result cannot be handed over.
  assign adv       = !clr_active_r && !(b_is_read && out_valid_r && !out_ready);
  assign pop       = head_valid && adv;
  assign b_addr    = b_entry_r.idx[ADDR_W-1:0];
  // The memory reads before it writes, so the write of the cycle in which this
  // entry's read was issued is picked up from the forwarding register.
  assign cur       = (fwd_valid_r && fwd_addr_r == b_addr) ? fwd_data_r : rd_data_r;
  assign cur_inc   = sat_inc(cur);
  assign b_write   = b_valid_r && adv && (b_entry_r.kind == ttvh_pkg::CMD_BIN);
  assign we        = clr_active_r || b_write;
  assign waddr     = clr_active_r ? clr_idx_r : b_addr;
  assign wdata     = clr_active_r ? '0 : cur_inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rd_data_r <= mem[head.idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_entry_r  <= head;
      fwd_addr_r <= b_addr;
      fwd_data_r <= cur_inc;
    end
    if (b_is_read && adv) begin
      out_data_r.bin_count      <= (b_entry_r.idx < ttvh_pkg::VAL_W'(NUM_BINS)) ?
                                   clip(cur) : '0;
      out_data_r.lines_seen     <= clip(line_cnt_r);
      out_data_r.dropped_values <= clip(drop_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      b_valid_r    <= 1'b0;
      fwd_valid_r  <= 1'b0;
      line_cnt_r   <= '0;
      drop_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + ADDR_W'(1);
        if (clr_idx_r == ADDR_W'(NUM_BINS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (adv) begin
        b_valid_r   <= pop;
        fwd_valid_r <= b_write;
      end
      if (b_valid_r && adv) begin
        if (b_entry_r.line_inc) begin
          line_cnt_r <= sat_inc(line_cnt_r);
        end
        if (b_entry_r.kind == ttvh_pkg::CMD_DROP) begin
          drop_cnt_r <= sat_inc(drop_cnt_r);
        end
      end
      if (b_is_read && adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!b_valid_r && !pop))
    else $error("bin update while clearing");
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !adv) |=> (b_valid_r && $stable(b_entry_r)))
    else $error("stalled update stage lost its entry");
`endif

endmodule

`default_nettype wire
